/* hdl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test package
// Shared types and fixed constants of the prime test unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int unsigned CAND_WIDTH    = 32;
    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned STEP_SHORT    = 2;
    localparam int unsigned STEP_LONG     = 4;

    typedef enum logic [1:0] {
        CLS_NOT_PRIME,
        CLS_PRIME,
        CLS_TRIAL
    } cls_t;

    typedef struct packed {
        logic valid;
        cls_t cls;
    } push_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_REPORT
    } back_state_t;

endpackage

/* hdl/tdpt_if.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test channels
// Valid/ready channels for the candidate items and the result items.
// ----------------------------------------------------------------------------
interface tdpt_cand_if;
    logic                                valid;
    logic                                ready;
    logic [tdpt_pkg::CAND_WIDTH-1:0]     candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);
endinterface

/* hdl/tdpt_front.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test front end
// Accepts candidates, trims them to the datapath width and sorts out the
// cases that need no trial division.
// ----------------------------------------------------------------------------
module tdpt_front #(
    parameter int unsigned NUM_WIDTH = 32
) (
    tdpt_cand_if.sink                cand,
    input  logic                     q_full,
    output tdpt_pkg::push_ctl_t      push_ctl,
    output logic [NUM_WIDTH-1:0]     push_n
);

    logic [63:0]          cand_ext;
    logic [NUM_WIDTH-1:0] n;

    assign cand_ext = {32'd0, cand.candidate};
    assign n        = cand_ext[NUM_WIDTH-1:0];

    assign cand.ready     = !q_full;
    assign push_n         = n;

    always_comb
    begin
        push_ctl.valid = cand.valid && !q_full;
        if (n <= NUM_WIDTH'(1))
        begin
            push_ctl.cls = tdpt_pkg::CLS_NOT_PRIME;
        end
        else if (n <= NUM_WIDTH'(3))
        begin
            push_ctl.cls = tdpt_pkg::CLS_PRIME;
        end
        else if (!n[0])
        begin
            push_ctl.cls = tdpt_pkg::CLS_NOT_PRIME;
        end
        else
        begin
            push_ctl.cls = tdpt_pkg::CLS_TRIAL;
        end
    end

endmodule

/* hdl/tdpt_queue.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test queue
// Two-entry queue between the front end and the trial engine.
// ----------------------------------------------------------------------------
module tdpt_queue #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tdpt_pkg::push_ctl_t      push_ctl,
    input  logic [NUM_WIDTH-1:0]     push_n,
    output logic                     full,
    output logic                     pop_valid,
    output tdpt_pkg::cls_t           pop_cls,
    output logic [NUM_WIDTH-1:0]     pop_n,
    input  logic                     pop
);

    logic [NUM_WIDTH-1:0] n_mem [2];
    tdpt_pkg::cls_t       cls_mem [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cls   = cls_mem[rd_ptr_reg];
    assign pop_n     = n_mem[rd_ptr_reg];
    assign do_push   = push_ctl.valid && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            n_mem[wr_ptr_reg]   <= push_n;
            cls_mem[wr_ptr_reg] <= push_ctl.cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hdl/tdpt_back.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test engine
// Runs the 6k-1 / 6k+1 trial divisions with a bit-serial remainder unit and
// holds the verdict in the output register.
// ----------------------------------------------------------------------------
module tdpt_back #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  tdpt_pkg::cls_t           q_cls,
    input  logic [NUM_WIDTH-1:0]     q_n,
    output logic                     q_pop,
    tdpt_result_if.source            res
);

    localparam int unsigned CW = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;
    localparam int unsigned SW = 2 * NUM_WIDTH;

    tdpt_pkg::back_state_t state_reg, state_next;
    logic [NUM_WIDTH-1:0]  n_reg, n_next;
    logic [NUM_WIDTH-1:0]  d_reg, d_next;
    logic [SW-1:0]         sq_reg, sq_next;
    logic                  long_reg, long_next;
    logic [NUM_WIDTH-1:0]  rem_reg, rem_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  verdict_reg, verdict_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_bit_reg, res_bit_next;
    logic                  slot_free;
    logic [NUM_WIDTH:0]    rem_shift;
    logic [NUM_WIDTH:0]    rem_sub;
    logic [SW-1:0]         sq_step;

    assign res.valid    = res_valid_reg;
    assign res.is_prime = res_bit_reg;
    assign slot_free    = !res_valid_reg || res.ready;

    assign rem_shift = {rem_reg, n_reg[cnt_reg]};
    assign rem_sub   = (rem_shift >= {1'b0, d_reg}) ? (rem_shift - {1'b0, d_reg}) : rem_shift;

    // (d+2)^2 - d^2 = 4d + 4 and (d+4)^2 - d^2 = 8d + 16.
    assign sq_step = long_reg ? (SW'({d_reg, 3'b000}) + SW'(16))
                              : (SW'({d_reg, 2'b00}) + SW'(4));

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        long_reg    <= long_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        verdict_reg <= verdict_next;
        res_bit_reg <= res_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        long_next      = long_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        verdict_next   = verdict_reg;
        res_bit_next   = res_bit_reg;
        res_valid_next = res_valid_reg && !res.ready;
        q_pop          = 1'b0;

        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cls)
                        tdpt_pkg::CLS_TRIAL:
                        begin
                            n_next     = q_n;
                            d_next     = NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
                            sq_next    = SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
                            long_next  = 1'b0;
                            state_next = tdpt_pkg::ST_CHECK;
                        end
                        tdpt_pkg::CLS_PRIME:
                        begin
                            verdict_next = 1'b1;
                            state_next   = tdpt_pkg::ST_REPORT;
                        end
                        default:
                        begin
                            verdict_next = 1'b0;
                            state_next   = tdpt_pkg::ST_REPORT;
                        end
                    endcase
                end
            end
            tdpt_pkg::ST_CHECK:
            begin
                if (sq_reg > SW'(n_reg))
                begin
                    verdict_next = 1'b1;
                    state_next   = tdpt_pkg::ST_REPORT;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CW'(NUM_WIDTH - 1);
                    state_next = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV:
            begin
                rem_next = rem_sub[NUM_WIDTH-1:0];
                if (cnt_reg == '0)
                begin
                    if (rem_sub == '0)
                    begin
                        verdict_next = 1'b0;
                        state_next   = tdpt_pkg::ST_REPORT;
                    end
                    else
                    begin
                        d_next     = d_reg + (long_reg ? NUM_WIDTH'(tdpt_pkg::STEP_LONG)
                                                       : NUM_WIDTH'(tdpt_pkg::STEP_SHORT));
                        sq_next    = sq_reg + sq_step;
                        long_next  = (d_reg == NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR)) ? 1'b0
                                                                                   : !long_reg;
                        state_next = tdpt_pkg::ST_CHECK;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            tdpt_pkg::ST_REPORT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_bit_next   = verdict_reg;
                    state_next     = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/trial_division_prime_test_unit.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test unit
// Reports for each candidate whether it is prime, using the 6k-1 / 6k+1 wheel.
// ----------------------------------------------------------------------------
// The candidate is cut to its low NUM_WIDTH bits and answered with one result
// item. Values up to 3 and even values are settled by the front end. Other
// values run through the trial engine, which tests divisor 3 and then 5, 7, 11,
// 13 and so on while the square of the divisor does not exceed the value; each
// divisor runs through the bit-serial remainder unit, and a composite stops at
// its smallest factor. A two-entry queue in front of the engine takes new items
// while a division runs, and the output register holds a finished result
// while the next item is worked on.
module trial_division_prime_test_unit #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    tdpt_cand_if.sink     cand,
    tdpt_result_if.source res
);

    tdpt_pkg::push_ctl_t  push_ctl;
    logic [NUM_WIDTH-1:0] push_n;
    logic                 q_full;
    logic                 q_valid;
    tdpt_pkg::cls_t       q_cls;
    logic [NUM_WIDTH-1:0] q_n;
    logic                 q_pop;

    tdpt_front #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .cand     (cand),
        .q_full   (q_full),
        .push_ctl (push_ctl),
        .push_n   (push_n)
    );

    tdpt_queue #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_ctl  (push_ctl),
        .push_n    (push_n),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_cls   (q_cls),
        .pop_n     (q_n),
        .pop       (q_pop)
    );

    tdpt_back #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cls   (q_cls),
        .q_n     (q_n),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

/* hdl/tdpt_checker.sv */
// ----------------------------------------------------------------------------
// Trial-division prime test checker
// Watches the ports of the prime test unit and flags handshake and occupancy
// errors.
// ----------------------------------------------------------------------------
module tdpt_checker (
    input logic clk,
    input logic rst_n,
    input logic cand_valid,
    input logic cand_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_is_prime
);

    logic [2:0] pending_reg;
    logic       cand_acc;
    logic       res_acc;

    assign cand_acc = cand_valid && cand_ready;
    assign res_acc  = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else if (cand_acc && !res_acc)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (res_acc && !cand_acc)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    res_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("Result item withdrawn before it was taken.");

    res_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_is_prime))
        else $error("Result item changed while stalled.");

    no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 3'd0)
        else $error("Result item shown with no item outstanding.");

    occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("More items outstanding than the unit can hold.");

    full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd4 |-> !cand_ready)
        else $error("Candidate item offered a slot while the unit is full.");

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cand_valid   (cand.valid),
    .cand_ready   (cand.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_is_prime (res.is_prime)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trial-division prime test unit testbench
// Sends 32-bit candidates to the unit and checks every result item against a
// primality predictor. The predictor tries 6k-1 and 6k+1 divisors, with a
// queue of expected answers in between. A directed table comes first. Random
// candidates follow, mostly small so that the trial loop stays short. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CAND_WIDTH     = tdpt_pkg::CAND_WIDTH;
    localparam int unsigned PRIME_WIDTH    = 32;
    localparam int          RANDOM_ITEMS   = 116;
    localparam int          WATCHDOG_LIMIT = 200000;
    localparam int          DRAIN_CYCLES   = 50;

    typedef struct packed {
        logic [CAND_WIDTH-1:0] value;
        logic                  typed;
        logic                  is_prime;
    } directed_row_t;

    typedef struct packed {
        logic [CAND_WIDTH-1:0] value;
        logic                  is_prime;
    } primality_t;

    localparam int N_DIRECTED = 24;

    // Rows marked typed carry an answer that is known outright; the others
    // take their answer from the predictor.
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b1},
        '{32'd3,          1'b1, 1'b1},
        '{32'd4,          1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b1, 1'b0},
        '{32'hFFFF_FFFE,  1'b1, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'd5,          1'b0, 1'b0},
        '{32'd6,          1'b0, 1'b0},
        '{32'd7,          1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0},
        '{32'd25,         1'b0, 1'b0},
        '{32'd35,         1'b0, 1'b0},
        '{32'd49,         1'b0, 1'b0},
        '{32'd97,         1'b0, 1'b0},
        '{32'd121,        1'b0, 1'b0},
        '{32'd143,        1'b0, 1'b0},
        '{32'd1001,       1'b0, 1'b0},
        '{32'd65521,      1'b0, 1'b0},
        '{32'd65537,      1'b0, 1'b0},
        '{32'h8000_0001,  1'b0, 1'b0},
        '{32'd16777213,   1'b0, 1'b0},
        '{32'd16752649,   1'b0, 1'b0}
    };

    logic clk;
    logic rst_n;

    tdpt_cand_if   cand_ch ();
    tdpt_result_if res_ch ();

    primality_t pending_answers [$];
    int         error_count = 0;
    int         quiet_cycles = 0;

    trial_division_prime_test_unit #(
        .NUM_WIDTH(PRIME_WIDTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic prime_by_trial(input logic [CAND_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned d;
        n = longint'(value) & ((64'd1 << PRIME_WIDTH) - 64'd1);
        if (n <= 1)
            return 1'b0;
        if (n <= 3)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        for (d = 5; d <= n / d; d += 6)
        begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [CAND_WIDTH-1:0] draw_candidate();
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (kind < 5)
            return $urandom_range(0, 255);
        else if (kind < 14)
            return $urandom_range(0, 65535);
        else if (kind < 16)
            return $urandom_range(0, 32'h000F_FFFF);
        else if (kind < 18)
            return $urandom & ~32'd1;
        else
            return $urandom_range(0, 32'h5555_5555) * 3;
    endfunction

    function automatic void check_result(input logic actual);
        primality_t expected;
        if (pending_answers.size() == 0)
        begin
            $display("%0t: result item with no candidate pending: expected none, got %0b",
                     $time, actual);
            error_count++;
        end
        else
        begin
            expected = pending_answers.pop_front();
            if (actual !== expected.is_prime)
            begin
                $display("%0t: candidate %0d: expected is_prime %0b, got %0b",
                         $time, expected.value, expected.is_prime, actual);
                error_count++;
            end
        end
    endfunction

    task automatic send_candidate(input logic [CAND_WIDTH-1:0] value, input logic answer,
                                  input bit steady);
        int gap;
        primality_t entry;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            cand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry.value    = value;
        entry.is_prime = answer;
        pending_answers = {pending_answers, entry};
        cand_ch.valid     <= 1'b1;
        cand_ch.candidate <= value;
        do @(posedge clk); while (!cand_ch.ready);
    endtask

    task automatic wait_for_answers();
        cand_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int stall;
        bit steady;
        res_ch.ready = 1'b0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            check_result(res_ch.is_prime);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int i;
        bit steady;
        logic [CAND_WIDTH-1:0] value;
        logic answer;
        steady            = 1'b0;
        rst_n             = 1'b0;
        cand_ch.valid     = 1'b0;
        cand_ch.candidate = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            value  = directed_rows[i].value;
            answer = directed_rows[i].typed ? directed_rows[i].is_prime : prime_by_trial(value);
            send_candidate(value, answer, i >= N_DIRECTED / 2);
        end
        wait_for_answers();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            if ($urandom_range(0, 19) == 0)
                wait_for_answers();
            value = draw_candidate();
            send_candidate(value, prime_by_trial(value), steady);
        end
        cand_ch.valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/tdpt_pkg.sv
hdl/tdpt_if.sv
hdl/tdpt_front.sv
hdl/tdpt_queue.sv
hdl/tdpt_back.sv
hdl/trial_division_prime_test_unit.sv
hdl/tdpt_checker.sv
tb/testbench.sv
